[src/lp_pkg.sv]
package lp_pkg;

	// Block configuration
	localparam int DEGREE     = 4;
	localparam int FRAC_BITS  = 16;
	localparam int RECIP_BITS = 24;

	// Port field widths
	localparam int IN_W  = 18;
	localparam int OUT_W = 18;

	// Internal widths: a value in -1.0 .. +1.0, a recurrence numerator, a reciprocal
	localparam int VAL_W = FRAC_BITS + 2;
	localparam int NUM_W = VAL_W + 5;
	localparam int RCP_W = RECIP_BITS + 1;
	localparam int IDX_W = 4;

	// Recurrence steps in the chain (degrees 0 and 1 need none)
	localparam int NSTEP = (DEGREE >= 2) ? DEGREE - 1 : 0;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t ONE = val_t'(64'sd1 <<< FRAC_BITS);

	// Item handed from one recurrence step to the next
	typedef struct packed {
		val_t x;
		val_t p1;
		val_t p2;
	} lp_item_t;

	// round(2^24 / i), i = 0 .. 15; entries 0 and 1 are never used
	localparam logic [RCP_W-1:0] RECIP_TABLE [16] = '{
		25'd0,       25'd16777216, 25'd8388608, 25'd5592405,
		25'd4194304, 25'd3355443,  25'd2796203, 25'd2396745,
		25'd2097152, 25'd1864135,  25'd1677722, 25'd1525201,
		25'd1398101, 25'd1290555,  25'd1198373, 25'd1118481
	};

	// Clamp to -1.0 .. +1.0
	function automatic val_t sat_unit(input logic signed [63:0] v);
		logic signed [63:0] one_w;
		one_w = 64'(ONE);
		if (v > one_w) begin
			return ONE;
		end else if (v < -one_w) begin
			return -ONE;
		end else begin
			return val_t'(v);
		end
	endfunction

endpackage

[src/lp_x_if.sv]
interface lp_x_if;
	import lp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] sample_x;

	modport source (output valid, output sample_x, input ready);
	modport sink   (input valid, input sample_x, output ready);
endinterface

[src/lp_p_if.sv]
interface lp_p_if;
	import lp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] poly_value;

	modport source (output valid, output poly_value, input ready);
	modport sink   (input valid, input poly_value, output ready);
endinterface

[src/lp_step.sv]
module lp_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lp_pkg::IDX_W-1:0]  step_idx,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lp_pkg::lp_item_t          in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lp_pkg::lp_item_t          out_item
);
	import lp_pkg::*;

	localparam int PROD_W = 2 * VAL_W;
	localparam int MUL_W  = NUM_W + RCP_W + 1;
	localparam int CF_W   = IDX_W + 2;

	localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [MUL_W-1:0]  HALF_R = MUL_W'(64'sd1 <<< (RECIP_BITS - 1));

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	val_t              x_s1, p1_s1, p2_s1, xp_s1;
	val_t              x_s2, p1_s2;
	logic signed [NUM_W-1:0] num_s2;
	lp_item_t          item_s3;

	logic signed [PROD_W-1:0] prod_c, prod_rnd_c;
	val_t                     xp_c;
	logic signed [CF_W-1:0]   c_odd, c_prev;
	logic signed [NUM_W-1:0]  num_c;
	logic signed [RCP_W:0]    rcp;
	logic signed [MUL_W-1:0]  mul_c, mul_rnd_c, mul_sh_c;
	val_t                     cur_c;

	// Stage advance: a stage takes new data when empty or when its successor takes
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: x * P(i-1), rounded half up to FRAC_BITS
	assign prod_c     = PROD_W'(in_item.x) * PROD_W'(in_item.p1);
	assign prod_rnd_c = prod_c + HALF_P;
	assign xp_c       = VAL_W'(prod_rnd_c >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			x_s1  <= in_item.x;
			p1_s1 <= in_item.p1;
			p2_s1 <= in_item.p2;
			xp_s1 <= xp_c;
		end
	end

	// Stage 2: numerator (2i-1) xp - (i-1) P(i-2), at full numerator width
	assign c_odd  = CF_W'({1'b0, step_idx, 1'b0} - (IDX_W + 1)'(1));
	assign c_prev = CF_W'({1'b0, step_idx - IDX_W'(1)});
	assign num_c  = NUM_W'(c_odd) * NUM_W'(xp_s1) - NUM_W'(c_prev) * NUM_W'(p2_s1);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			x_s2   <= x_s1;
			p1_s2  <= p1_s1;
			num_s2 <= num_c;
		end
	end

	// Stage 3: divide by i through the reciprocal, round, clamp
	assign rcp       = {1'b0, RECIP_TABLE[step_idx]};
	assign mul_c     = MUL_W'(num_s2) * MUL_W'(rcp);
	assign mul_rnd_c = mul_c + HALF_R;
	assign mul_sh_c  = mul_rnd_c >>> RECIP_BITS;
	assign cur_c     = sat_unit(64'(mul_sh_c));

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			item_s3 <= '{x: x_s2, p1: cur_c, p2: p1_s2};
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

	// A stalled last stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |=> valid_s3 && $stable(item_s3))
		else $error("lp_step: stage 3 item changed under stall");

	// A middle stage blocked by stage 3 keeps its numerator
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s3 |=> valid_s2 && $stable(num_s2))
		else $error("lp_step: stage 2 numerator changed under stall");

	// Every term leaving the step lies in -1.0 .. +1.0
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (item_s3.p1 <= ONE) && (item_s3.p1 >= -ONE))
		else $error("lp_step: term out of unit range");

endmodule

[src/legendre_polynomial_eval.sv]
// Legendre polynomial evaluator, fixed degree lp_pkg::DEGREE.
//
// samples (sink): one evaluation point sample_x per transfer, signed with
// FRAC_BITS fraction bits; values beyond +/-1.0 are clamped first.
// results (source): one poly_value per sample, in order, P_DEGREE(x) with
// FRAC_BITS fraction bits, clamped to -1.0 .. +1.0.
//
// Pipeline: one input register, three stages per recurrence step
// (multiply x by P(i-1), form the numerator, multiply by 1/i) for degrees 2 to
// DEGREE, then an output register. Throughput is one sample per cycle while
// results is not stalled; the multipliers of the first and third stage of each
// step set the clock.
//
// Reset clears all valid bits; samples is ready as soon as reset is released.
// When the receiver stalls, results waits with its value held and each stage
// keeps filling up to the first occupied one, so samples keeps being taken
// until the pipeline is full.
module legendre_polynomial_eval (
	input logic clk,
	input logic arst_n,
	lp_x_if.sink   samples,
	lp_p_if.source results
);
	import lp_pkg::*;

	logic     valid_s0, ready_s0;
	lp_item_t item_s0;
	val_t     x_sat;

	logic     link_valid [NSTEP+1];
	logic     link_ready [NSTEP+1];
	lp_item_t link_item  [NSTEP+1];

	logic                    valid_q;
	logic signed [OUT_W-1:0] value_q;
	val_t                    final_c;

	// Input register: clamp the sample and seed P0 = 1, P1 = x
	assign x_sat         = sat_unit(64'(samples.sample_x));
	assign ready_s0      = !valid_s0 || link_ready[0];
	assign samples.ready = ready_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (ready_s0) begin
			valid_s0 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s0 && samples.valid) begin
			item_s0 <= '{x: x_sat, p1: x_sat, p2: ONE};
		end
	end

	assign link_valid[0] = valid_s0;
	assign link_item[0]  = item_s0;

	// Recurrence chain, degree k+2 in step k
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		lp_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.step_idx  (IDX_W'(k + 2)),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_item   (link_item[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_item  (link_item[k+1])
		);
	end

	// Output register
	assign final_c          = (DEGREE == 0) ? ONE : link_item[NSTEP].p1;
	assign link_ready[NSTEP] = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (link_ready[NSTEP]) begin
			valid_q <= link_valid[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (link_ready[NSTEP] && link_valid[NSTEP]) begin
			value_q <= OUT_W'(final_c);
		end
	end

	assign results.valid      = valid_q;
	assign results.poly_value = value_q;

	// The clamped sample in the input register stays within -1.0 .. +1.0
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s0 |-> (item_s0.x <= ONE) && (item_s0.x >= -ONE) && (item_s0.p1 == item_s0.x))
		else $error("legendre_polynomial_eval: input stage out of range");

	// A waiting result is neither lost nor altered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !results.ready |=> valid_q && $stable(value_q))
		else $error("legendre_polynomial_eval: result changed while waiting");

endmodule
